/* hw/rtl/tpsg_pkg.sv */
// ----------------------------------------------------------------------------
// tpsg_pkg
// Shared types, register map and colour tables for the playfield and sprite
// pixel generator.
// ----------------------------------------------------------------------------
package tpsg_pkg;

  // default video geometry
  localparam int unsigned LINE_WIDTH_DEF  = 160;
  localparam int unsigned LINE_COUNT_DEF  = 192;
  localparam int unsigned SPRITE_ROWS_DEF = 8;

  // playfield layout
  localparam int unsigned PF_BITS    = 20;
  localparam int unsigned BLOCK_BITS = 2;   // four pixels per playfield bit

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  // video register map
  typedef enum logic [5:0] {
    REG_COLUP0 = 6'h06,
    REG_COLUP1 = 6'h07,
    REG_COLUPF = 6'h08,
    REG_COLUBK = 6'h09,
    REG_CTRLPF = 6'h0A,
    REG_PF0    = 6'h0D,
    REG_PF1    = 6'h0E,
    REG_PF2    = 6'h0F,
    REG_RESP0  = 6'h10,
    REG_RESP1  = 6'h11,
    REG_GRP0   = 6'h1B,
    REG_GRP1   = 6'h1C
  } reg_addr_t;

  // 3-bit level scaled by 255/7, truncated
  function automatic logic [7:0] scale3(input logic [2:0] lvl);
    logic [7:0] v;
    case (lvl)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd36;
      3'd2:    v = 8'd72;
      3'd3:    v = 8'd109;
      3'd4:    v = 8'd145;
      3'd5:    v = 8'd182;
      3'd6:    v = 8'd218;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // 2-bit level scaled by 255/3
  function automatic logic [7:0] scale2(input logic [1:0] lvl);
    return {4{lvl}};
  endfunction

endpackage

/* hw/rtl/tpsg_req_if.sv */
// ----------------------------------------------------------------------------
// tpsg_req_if
// Request channel: register write or pixel request.
// ----------------------------------------------------------------------------
interface tpsg_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [5:0] register_address;
  logic [7:0] write_data;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;

  modport source (
    output valid, kind, register_address, write_data, pixel_x, pixel_y,
    input  ready
  );

  modport sink (
    input  valid, kind, register_address, write_data, pixel_x, pixel_y,
    output ready
  );
endinterface

/* hw/rtl/tpsg_rsp_if.sv */
// ----------------------------------------------------------------------------
// tpsg_rsp_if
// Response channel: one RGB pixel.
// ----------------------------------------------------------------------------
interface tpsg_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (
    output valid, red, green, blue,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue,
    output ready
  );
endinterface

/* hw/rtl/tia_playfield_sprite_pixel_generator.sv */
// Path: a pixel request passes through the input stage and then the output
// register before its result is valid on rsp.
// Throughput: one item per cycle while req.ready is high; a register write
// takes one slot, no result. req.ready drops only while a pixel waits in the
// input stage for a full output register. rst (synchronous) empties both
// stages and clears all twelve video registers to zero.
// ----------------------------------------------------------------------------
// tia_playfield_sprite_pixel_generator
// Playfield and two-sprite pixel generator with a 12-register video map.
// ----------------------------------------------------------------------------
module tia_playfield_sprite_pixel_generator #(
  parameter int unsigned LINE_WIDTH  = tpsg_pkg::LINE_WIDTH_DEF,
  parameter int unsigned LINE_COUNT  = tpsg_pkg::LINE_COUNT_DEF,
  parameter int unsigned SPRITE_ROWS = tpsg_pkg::SPRITE_ROWS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  tpsg_req_if.sink req,
  tpsg_rsp_if.source rsp
);
  import tpsg_pkg::*;

  // x arithmetic width: holds LINE_WIDTH and an 8-bit x
  localparam int unsigned PW = ($clog2(LINE_WIDTH + 1) > 8) ? $clog2(LINE_WIDTH + 1) : 8;
  localparam int unsigned YW = ($clog2(LINE_COUNT + 1) > 8) ? $clog2(LINE_COUNT + 1) : 8;
  localparam int unsigned BW = PW - BLOCK_BITS;

  localparam logic [PW-1:0] LW_C    = PW'(LINE_WIDTH);
  localparam logic [PW-1:0] LW_M1_C = PW'(LINE_WIDTH - 1);
  localparam logic [PW-1:0] HALF_C  = PW'(LINE_WIDTH / 2);
  localparam logic [PW-1:0] FULL_C  = PW'(2 * (LINE_WIDTH / 2));
  localparam logic [YW-1:0] LC_C    = YW'(LINE_COUNT);
  localparam logic [7:0]    ROWS_C  = 8'(SPRITE_ROWS);
  localparam logic [BW-1:0] PFB_C   = BW'(PF_BITS);

  // --------------------------------------------------------------------------
  // Video registers
  // --------------------------------------------------------------------------
  logic [7:0] colup0, colup1, colupf, colubk;
  logic [7:0] ctrlpf;
  logic [7:0] pf0, pf1, pf2;
  logic [7:0] resp0, resp1;
  logic [7:0] grp0, grp1;

  // --------------------------------------------------------------------------
  // Input stage
  // --------------------------------------------------------------------------
  logic       s1_valid;
  logic       s1_kind;
  logic [5:0] s1_addr;
  logic [7:0] s1_data;
  logic [7:0] s1_x;
  logic [7:0] s1_y;

  // output register
  logic       o_valid;
  logic [7:0] o_red, o_green, o_blue;

  logic out_free;
  logic s1_adv;
  logic s1_load;

  // A write leaves the input stage at once; a pixel needs room in the
  // output register.
  assign out_free = !o_valid || rsp.ready;
  assign s1_adv   = s1_valid && ((s1_kind == KIND_WRITE) || out_free);
  assign req.ready = !s1_valid || s1_adv;
  assign s1_load  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind <= req.kind;
      s1_addr <= req.register_address;
      s1_data <= req.write_data;
      s1_x    <= req.pixel_x;
      s1_y    <= req.pixel_y;
    end
  end

  // --------------------------------------------------------------------------
  // Register writes: take effect as the write leaves the input stage, so a
  // pixel behind it always sees it. Unknown addresses fall through.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      colup0 <= '0;
      colup1 <= '0;
      colupf <= '0;
      colubk <= '0;
      ctrlpf <= '0;
      pf0    <= '0;
      pf1    <= '0;
      pf2    <= '0;
      resp0  <= '0;
      resp1  <= '0;
      grp0   <= '0;
      grp1   <= '0;
    end else if (s1_adv && (s1_kind == KIND_WRITE)) begin
      case (s1_addr)
        REG_COLUP0: colup0 <= s1_data;
        REG_COLUP1: colup1 <= s1_data;
        REG_COLUPF: colupf <= s1_data;
        REG_COLUBK: colubk <= s1_data;
        REG_CTRLPF: ctrlpf <= s1_data;
        REG_PF0:    pf0    <= s1_data;
        REG_PF1:    pf1    <= s1_data;
        REG_PF2:    pf2    <= s1_data;
        REG_RESP0:  resp0  <= s1_data;
        REG_RESP1:  resp1  <= s1_data;
        REG_GRP0:   grp0   <= s1_data;
        REG_GRP1:   grp1   <= s1_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pixel logic
  // --------------------------------------------------------------------------
  logic [PW-1:0]      x_ext;
  logic [PW-1:0]      pos_m;     // after mirroring
  logic [PW-1:0]      pos;       // position within the half line
  logic [BW-1:0]      pf_idx;
  logic [PF_BITS-1:0] pf_vec;
  logic               pf_hit;
  logic               on_screen;
  logic               row_ok;
  logic [7:0]         off0, off1;
  logic               sp0_hit, sp1_hit;
  logic [7:0]         colour;

  assign x_ext     = PW'(s1_x);
  assign on_screen = (x_ext < LW_C) && (YW'(s1_y) < LC_C);

  // Playfield bit order across a half line: PF0[4..7], PF1[7..0], PF2[0..7].
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pf_vec[i] = pf0[4 + i];
    end
    for (int i = 0; i < 8; i++) begin
      pf_vec[4 + i]  = pf1[7 - i];
      pf_vec[12 + i] = pf2[i];
    end
  end

  always_comb begin
    if (ctrlpf[0] && (x_ext >= HALF_C)) begin
      pos_m = LW_M1_C - x_ext;
    end else begin
      pos_m = x_ext;
    end
    // fold into the half line; an odd line width can reach twice the half
    if (pos_m >= FULL_C) begin
      pos = pos_m - FULL_C;
    end else if (pos_m >= HALF_C) begin
      pos = pos_m - HALF_C;
    end else begin
      pos = pos_m;
    end
  end

  assign pf_idx = pos[PW-1:BLOCK_BITS];
  // wide lines leave blocks past the 20th bit blank
  assign pf_hit = (pf_idx < PFB_C) && pf_vec[pf_idx[4:0]];

  // Sprites: eight pixels from the position column, MSB leftmost.
  assign row_ok  = s1_y < ROWS_C;
  assign off0    = s1_x - resp0;
  assign off1    = s1_x - resp1;
  assign sp0_hit = row_ok && (s1_x >= resp0) && (off0 < 8'd8) && grp0[~off0[2:0]];
  assign sp1_hit = row_ok && (s1_x >= resp1) && (off1 < 8'd8) && grp1[~off1[2:0]];

  // priority: off screen shows the background; else sprite 1, sprite 0, playfield, background
  always_comb begin
    if (!on_screen) begin
      colour = colubk;
    end else if (sp1_hit) begin
      colour = colup1;
    end else if (sp0_hit) begin
      colour = colup0;
    end else if (pf_hit) begin
      colour = colupf;
    end else begin
      colour = colubk;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic o_load;
  assign o_load = s1_adv && (s1_kind == KIND_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_red   <= scale3(colour[7:5]);
      o_green <= scale3(colour[4:2]);
      o_blue  <= scale2(colour[1:0]);
    end
  end

  assign rsp.valid = o_valid;
  assign rsp.red   = o_red;
  assign rsp.green = o_green;
  assign rsp.blue  = o_blue;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input stage only stalls behind a pixel that cannot move on.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (s1_valid && (s1_kind == KIND_PIXEL) && o_valid && !rsp.ready))
    else $error("req stalled without a blocked pixel");

  // A pixel with room ahead is valid on rsp in the next cycle.
  a_pixel_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_kind == KIND_PIXEL) && out_free) |=> rsp.valid)
    else $error("pixel request lost");

  // Nothing appears on rsp unless a pixel was in the input stage.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (!(s1_valid && (s1_kind == KIND_PIXEL)) && out_free) |=> !rsp.valid)
    else $error("result without a pixel request");

  // Blue comes from a 2-bit level replicated across the byte.
  a_blue_levels: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.blue == {4{rsp.blue[1:0]}}))
    else $error("blue level out of table");

endmodule

/* test/tb_tia_playfield_sprite_pixel_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tia_playfield_sprite_pixel_generator
// Drives register writes and pixel requests into the pixel generator and
// compares every returned RGB pixel against a shadow copy of the video
// registers kept in the bench. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_tia_playfield_sprite_pixel_generator;
  import tpsg_pkg::*;

  // geometry as built into the block under test
  localparam int unsigned LINE_W     = LINE_WIDTH_DEF;
  localparam int unsigned LINE_H     = LINE_COUNT_DEF;
  localparam int unsigned SPR_ROWS   = SPRITE_ROWS_DEF;
  localparam int unsigned HALF_W     = LINE_W / 2;
  localparam int unsigned PF_BLOCK   = 1 << BLOCK_BITS;

  localparam int          RANDOM_ITEMS  = 1150;
  localparam int          CALM_ITEMS    = 120;   // tail of the run with no idling
  localparam int          STALL_LIMIT   = 2000;  // cycles with no transfer at all
  localparam int          DRAIN_CYCLES  = 8;     // settle time after the last pixel
  localparam int          REPORT_MAX    = 10;

  typedef struct {
    kind_t      kind;
    logic [5:0] addr;
    logic [7:0] data;
    logic [7:0] px;
    logic [7:0] py;
    bit         drain_first;  // hold off until all pixels are back
  } video_op_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tpsg_req_if req_ch ();
  tpsg_rsp_if rsp_ch ();

  tia_playfield_sprite_pixel_generator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow video registers, all zero out of reset
  // --------------------------------------------------------------------------
  logic [7:0] colup0 = '0, colup1 = '0, colupf = '0, colubk = '0;
  logic [7:0] ctrlpf = '0;
  logic [7:0] pf0 = '0, pf1 = '0, pf2 = '0;
  logic [7:0] grp0 = '0, grp1 = '0;
  logic [7:0] resp0 = '0, resp1 = '0;

  video_op_t pending_ops[$];
  rgb_t      pixels_due[$];

  reg_addr_t video_map[12] = '{REG_COLUP0, REG_COLUP1, REG_COLUPF, REG_COLUBK,
                               REG_CTRLPF, REG_PF0, REG_PF1, REG_PF2,
                               REG_RESP0, REG_RESP1, REG_GRP0, REG_GRP1};

  int  fault_count = 0;
  int  idle_cycles = 0;
  bit  req_xfer = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Unmapped addresses fall through the case and leave everything untouched.
  task automatic store_video_reg(input logic [5:0] addr, input logic [7:0] data);
    case (reg_addr_t'(addr))
      REG_COLUP0: colup0 = data;
      REG_COLUP1: colup1 = data;
      REG_COLUPF: colupf = data;
      REG_COLUBK: colubk = data;
      REG_CTRLPF: ctrlpf = data;
      REG_PF0:    pf0    = data;
      REG_PF1:    pf1    = data;
      REG_PF2:    pf2    = data;
      REG_RESP0:  resp0  = data;
      REG_RESP1:  resp1  = data;
      REG_GRP0:   grp0   = data;
      REG_GRP1:   grp1   = data;
      default: ;
    endcase
  endtask

  function automatic bit sprite_hit(input logic [7:0] gfx, input logic [7:0] left,
                                    input logic [7:0] px, input logic [7:0] py);
    int col;
    if (py >= SPR_ROWS || px < left) return 1'b0;
    col = int'(px) - int'(left);
    if (col >= 8) return 1'b0;
    return gfx[7 - col];
  endfunction

  // Playfield bit order per half line: PF0[4..7], PF1[7..0], PF2[0..7].
  function automatic bit playfield_hit(input logic [7:0] px);
    int pos;
    int pf_bit;
    pos = int'(px);
    if (ctrlpf[0] && pos >= HALF_W) pos = LINE_W - 1 - pos;  // mirrored right half
    pos = pos % HALF_W;
    pf_bit = pos / PF_BLOCK;
    if (pf_bit >= PF_BITS) return 1'b0;
    if (pf_bit < 4) return pf0[4 + pf_bit];
    if (pf_bit < 12) return pf1[7 - (pf_bit - 4)];
    return pf2[pf_bit - 12];
  endfunction

  // 3:3:2 colour byte to 8-bit channels, truncating division
  function automatic rgb_t expand_colour(input logic [7:0] c);
    rgb_t v;
    int   r, g, b;
    r = (int'(c[7:5]) * 255) / 7;
    g = (int'(c[4:2]) * 255) / 7;
    b = (int'(c[1:0]) * 255) / 3;
    v.red   = r[7:0];
    v.green = g[7:0];
    v.blue  = b[7:0];
    return v;
  endfunction

  function automatic rgb_t shade_pixel(input logic [7:0] px, input logic [7:0] py);
    logic [7:0] colour;
    colour = colubk;
    if (px < LINE_W && py < LINE_H) begin
      if (sprite_hit(grp1, resp1, px, py))      colour = colup1;
      else if (sprite_hit(grp0, resp0, px, py)) colour = colup0;
      else if (playfield_hit(px))               colour = colupf;
    end
    return expand_colour(colour);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  task automatic add_write(input logic [5:0] addr, input logic [7:0] data);
    video_op_t op;
    op.kind = KIND_WRITE;
    op.addr = addr;
    op.data = data;
    op.px = 8'($urandom);   // don't-care fields still toggle
    op.py = 8'($urandom);
    op.drain_first = 1'b0;
    pending_ops.push_back(op);
  endtask

  task automatic add_pixel(input logic [7:0] px, input logic [7:0] py);
    video_op_t op;
    op.kind = KIND_PIXEL;
    op.addr = 6'($urandom);
    op.data = 8'($urandom);
    op.px = px;
    op.py = py;
    op.drain_first = 1'b0;
    pending_ops.push_back(op);
  endtask

  task automatic build_directed();
    add_pixel(8'd0, 8'd0);                  // everything still zero from reset
    add_write(REG_COLUBK, 8'h03);
    add_write(REG_COLUPF, 8'hFF);
    add_write(REG_COLUP0, 8'h1C);
    add_write(REG_COLUP1, 8'hE0);
    add_write(REG_PF0, 8'hF0);
    add_write(REG_PF2, 8'h80);
    add_pixel(8'd0, 8'd100);                // first PF0 block
    add_pixel(8'd79, 8'd100);               // last PF2 block, left half
    add_pixel(8'd80, 8'd100);               // repeated right half
    add_write(REG_CTRLPF, 8'h01);
    add_pixel(8'd80, 8'd100);               // mirrored: PF2 block at the centre
    add_write(6'h00, 8'hFF);                // unmapped, low end
    add_write(6'h3F, 8'hFF);                // unmapped, high end
    add_write(REG_GRP0, 8'h81);
    add_pixel(8'd7, 8'd7);                  // sprite 0 last column, last row
    add_pixel(8'd7, 8'd8);                  // first row below the sprites
    add_write(REG_RESP1, 8'd152);
    add_write(REG_GRP1, 8'hFF);
    add_pixel(8'd159, 8'd7);                // sprite 1 at the line end
    add_write(REG_RESP1, 8'd0);
    add_pixel(8'd0, 8'd0);                  // both sprites overlap, sprite 1 wins
    add_write(REG_RESP0, 8'd255);           // sprite past the line end
    add_pixel(8'd160, 8'd0);                // off screen, right
    add_pixel(8'd255, 8'd255);              // off screen, both
    add_pixel(8'd159, 8'd191);              // last on-screen pixel
  endtask

  task automatic build_random();
    int         sel;
    reg_addr_t  ra;
    logic [7:0] d;
    logic [7:0] px, py;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 40) begin
        if ($urandom_range(0, 99) < 85) begin
          ra = video_map[$urandom_range(0, 11)];
          d  = 8'($urandom);
          // keep most sprites on screen so they are actually hit
          if ((ra == REG_RESP0 || ra == REG_RESP1) && $urandom_range(0, 9) < 7)
            d = 8'($urandom_range(0, LINE_W - 1));
          add_write(ra, d);
        end else begin
          add_write(6'($urandom), 8'($urandom));
        end
      end else begin
        px = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, LINE_W - 1))
                                          : 8'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 5)      py = 8'($urandom_range(0, SPR_ROWS + 1));
        else if (sel < 9) py = 8'($urandom_range(0, LINE_H - 1));
        else              py = 8'($urandom);
        add_pixel(px, py);
      end
      // a couple of points where the sender waits for the pipe to empty
      if (n == 400 || n == 800) pending_ops[$].drain_first = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver, falling edge
  // --------------------------------------------------------------------------
  int src_gap = 0;
  int src_pct = 0;
  int src_cycles = 0;

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      src_cycles <= src_cycles + 1;
      if (src_cycles % 256 == 0) begin
        case ($urandom_range(0, 2))
          0:       src_pct <= 0;
          1:       src_pct <= 10;
          default: src_pct <= 35;
        endcase
      end
      if (!req_ch.valid || req_xfer) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain_first && pixels_due.size() != 0)) begin
          if (pending_ops.size() > CALM_ITEMS && $urandom_range(0, 99) < src_pct) begin
            src_gap <= $urandom_range(0, 18);   // start a random burst of idle cycles
            req_ch.valid <= 1'b0;
          end else begin
            req_ch.valid            <= 1'b1;
            req_ch.kind             <= pending_ops[0].kind;
            req_ch.register_address <= pending_ops[0].addr;
            req_ch.write_data       <= pending_ops[0].data;
            req_ch.pixel_x          <= pending_ops[0].px;
            req_ch.pixel_y          <= pending_ops[0].py;
            pending_ops.pop_front();
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response back-pressure, falling edge
  // --------------------------------------------------------------------------
  int snk_stall = 0;
  int snk_pct = 0;
  int snk_cycles = 0;

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      snk_cycles <= snk_cycles + 1;
      if (snk_cycles % 200 == 0) begin
        case ($urandom_range(0, 2))
          0:       snk_pct <= 0;
          1:       snk_pct <= 8;
          default: snk_pct <= 30;
        endcase
      end
      if (snk_stall != 0) begin
        snk_stall <= snk_stall - 1;
        rsp_ch.ready <= 1'b0;
      end else if (pending_ops.size() > CALM_ITEMS && $urandom_range(0, 99) < snk_pct) begin
        snk_stall <= $urandom_range(0, 18);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Rising edge: update the shadow registers on each request transfer and
  // check each pixel transfer against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    req_xfer <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && req_ch.valid && req_ch.ready) begin
      if (req_ch.kind == KIND_WRITE)
        store_video_reg(req_ch.register_address, req_ch.write_data);
      else
        pixels_due.push_back(shade_pixel(req_ch.pixel_x, req_ch.pixel_y));
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pixels_due.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("unexpected pixel: got %0d/%0d/%0d",
                   rsp_ch.red, rsp_ch.green, rsp_ch.blue);
      end else begin
        if (rsp_ch.red !== pixels_due[0].red || rsp_ch.green !== pixels_due[0].green ||
            rsp_ch.blue !== pixels_due[0].blue) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("pixel mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                     pixels_due[0].red, pixels_due[0].green, pixels_due[0].blue,
                     rsp_ch.red, rsp_ch.green, rsp_ch.blue);
        end
        pixels_due.pop_front();
      end
    end
  end

  // watchdog: ends a run in which nothing moves on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[tia_playfield_sprite_pixel_generator] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build stimulus, release reset, wait for the pipe to drain
  // --------------------------------------------------------------------------
  initial begin
    req_ch.valid            = 1'b0;
    req_ch.kind             = KIND_WRITE;
    req_ch.register_address = '0;
    req_ch.write_data       = '0;
    req_ch.pixel_x          = '0;
    req_ch.pixel_y          = '0;
    rsp_ch.ready            = 1'b0;
    build_directed();
    build_random();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (pending_ops.size() != 0 || req_ch.valid) @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && pixels_due.size() == 0) begin
      $display("[tia_playfield_sprite_pixel_generator] OK");
    end else begin
      $display("[tia_playfield_sprite_pixel_generator] ERROR");
    end
    $finish;
  end

endmodule
